[hw/rtl/lcp_pkg.sv]
`default_nettype none

package lcp_pkg;

   // Threshold registers are all this wide; the CSR write data matches it.
   localparam int LEVEL_W     = 16;
   localparam int CSR_INDEX_W = 3;

   // CSR register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ABS_TRIP     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FAST_JUMP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MID_JUMP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_JUMP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RECOVER      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIFT_MIN    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_QUIET_CYC    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_RECOVER_CYC  = 3'd7;

   // Run lengths for the sustained trips and the calm timeout
   localparam logic [3:0] ABS_TRIP_RUN = 4'd12;
   localparam logic [3:0] MID_TRIP_RUN = 4'd8;
   localparam logic [3:0] LOW_TRIP_RUN = 4'd8;
   localparam logic [4:0] CALM_RUN     = 5'd26;

   // Baseline kind bits
   localparam logic [1:0] KIND_NONE = 2'b00;
   localparam logic [1:0] KIND_MID  = 2'b10;
   localparam logic [1:0] KIND_LOW  = 2'b01;

   typedef struct packed {
      logic [LEVEL_W-1:0] abs_trip_level;
      logic [LEVEL_W-1:0] fast_jump_level;
      logic [LEVEL_W-1:0] mid_jump_level;
      logic [LEVEL_W-1:0] low_jump_level;
      logic [LEVEL_W-1:0] recover_level;
      logic [LEVEL_W-1:0] drift_min_level;
      logic [7:0]         quiet_cycles;
      logic [8:0]         recover_cycles;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      abs_trip_level:  16'd2800,
      fast_jump_level: 16'd1200,
      mid_jump_level:  16'd480,
      low_jump_level:  16'd240,
      recover_level:   16'd500,
      drift_min_level: 16'd10,
      quiet_cycles:    8'd150,
      recover_cycles:  9'd276
   };

   // Counters and flags carried from one beat to the next
   typedef struct packed {
      logic [7:0] quiet_count;
      logic [3:0] abs_count;
      logic [3:0] mid_count;
      logic [3:0] low_count;
      logic [4:0] calm_count;
      logic       jump_active;
      logic [1:0] base_kind;
      logic [8:0] recover_count;
      logic       fault_flag;
   } ctrl_type;

   localparam ctrl_type CTRL_RESET = '{
      quiet_count:   8'd0,
      abs_count:     4'd0,
      mid_count:     4'd0,
      low_count:     4'd0,
      calm_count:    5'd0,
      jump_active:   1'b0,
      base_kind:     KIND_NONE,
      recover_count: 9'd0,
      fault_flag:    1'b0
   };

   typedef struct packed {
      logic leak_fault;
      logic fault_raised;
      logic fault_cleared;
      logic jump_tracking;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/leakage_current_protection.sv]
// Channel  | Direction | Beat contents                                     | Handshake
// ---------+-----------+---------------------------------------------------+----------------
// req_     | in        | rms_sample, avg_sample, grid_connected, restart_q | valid / ready
// rsp_     | out       | leak_fault, fault_raised, fault_cleared, jump_trk | valid / ready
// csr_     | in        | index 0..7, 16-bit write data                     | write enable
//
// One beat per clock sustained while the rsp_ channel does not stall. A beat passes the
// input register, then the next-state logic into the result register, which loads at
// the edge after the request beat is accepted unless an untaken result still sits there.
// The state update sits between those two registers, so each beat sees the state
// left by the one before it.
// Reset (synchronous, active high) loads the default thresholds and clears the control state.
// A stalled rsp_ channel holds the result register; the input register still takes a
// beat while the result waits if it is empty, and then holds that beat until it moves on.
`default_nettype none

module leakage_current_protection #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,

   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire         [SAMPLE_BITS-1:0]           req_rms_sample,
   input  wire  signed [SAMPLE_BITS-1:0]           req_avg_sample,
   input  wire                                     req_grid_connected,
   input  wire                                     req_restart_quiet,

   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic                                    rsp_leak_fault,
   output logic                                    rsp_fault_raised,
   output logic                                    rsp_fault_cleared,
   output logic                                    rsp_jump_tracking,

   input  wire                                     csr_we,
   input  wire         [lcp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire         [lcp_pkg::LEVEL_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------- config
   lcp_pkg::cfg_type cfg_ff;
   lcp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lcp_pkg::REG_ABS_TRIP:    cfg_in.abs_trip_level  = csr_wdata;
            lcp_pkg::REG_FAST_JUMP:   cfg_in.fast_jump_level = csr_wdata;
            lcp_pkg::REG_MID_JUMP:    cfg_in.mid_jump_level  = csr_wdata;
            lcp_pkg::REG_LOW_JUMP:    cfg_in.low_jump_level  = csr_wdata;
            lcp_pkg::REG_RECOVER:     cfg_in.recover_level   = csr_wdata;
            lcp_pkg::REG_DRIFT_MIN:   cfg_in.drift_min_level = csr_wdata;
            lcp_pkg::REG_QUIET_CYC:   cfg_in.quiet_cycles    = csr_wdata[7:0];
            lcp_pkg::REG_RECOVER_CYC: cfg_in.recover_cycles  = csr_wdata[8:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lcp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------- input stage
   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic        [SAMPLE_BITS-1:0] in_rms_ff;
   logic signed [SAMPLE_BITS-1:0] in_avg_ff;
   logic                          in_grid_ff;
   logic                          in_restart_ff;
   logic                          req_fire;
   logic                          advance;

   // Advance the held beat into the result register when that slot frees up.
   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload: capture only on an accepted beat, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_rms_ff     <= req_rms_sample;
         in_avg_ff     <= req_avg_sample;
         in_grid_ff    <= req_grid_connected;
         in_restart_ff <= req_restart_quiet;
      end
   end

   // ------------------------------------------------------ protection state
   // History keeps the last two samples: [1] is the previous beat, [0] the one
   // before. The current sample is compared against [0].
   logic        [SAMPLE_BITS-1:0] rms_hist_ff [2];
   logic signed [SAMPLE_BITS-1:0] avg_hist_ff [2];
   logic        [SAMPLE_BITS-1:0] base_rms_ff;
   logic        [SAMPLE_BITS-1:0] base_rms_in;
   logic signed [SAMPLE_BITS-1:0] base_avg_ff;
   logic signed [SAMPLE_BITS-1:0] base_avg_in;
   lcp_pkg::ctrl_type             ctrl_ff;
   lcp_pkg::ctrl_type             ctrl_in;
   lcp_pkg::rsp_type              step_rsp;

   lcp_step #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_step (
      .cfg           (cfg_ff),
      .ctrl          (ctrl_ff),
      .rms           (in_rms_ff),
      .avg           (in_avg_ff),
      .grid          (in_grid_ff),
      .restart       (in_restart_ff),
      .rms_prev2     (rms_hist_ff[0]),
      .avg_prev2     (avg_hist_ff[0]),
      .base_rms      (base_rms_ff),
      .base_avg      (base_avg_ff),
      .ctrl_next     (ctrl_in),
      .base_rms_next (base_rms_in),
      .base_avg_next (base_avg_in),
      .rsp           (step_rsp)
   );

   // State moves only when a beat leaves the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff        <= lcp_pkg::CTRL_RESET;
         base_rms_ff    <= '0;
         base_avg_ff    <= '0;
         rms_hist_ff[0] <= '0;
         rms_hist_ff[1] <= '0;
         avg_hist_ff[0] <= '0;
         avg_hist_ff[1] <= '0;
      end else if (advance) begin
         ctrl_ff        <= ctrl_in;
         base_rms_ff    <= base_rms_in;
         base_avg_ff    <= base_avg_in;
         rms_hist_ff[0] <= rms_hist_ff[1];
         rms_hist_ff[1] <= in_rms_ff;
         avg_hist_ff[0] <= avg_hist_ff[1];
         avg_hist_ff[1] <= in_avg_ff;
      end
   end

   // --------------------------------------------------------- result stage
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   lcp_pkg::rsp_type rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_leak_fault    = rsp_ff.leak_fault;
   assign rsp_fault_raised  = rsp_ff.fault_raised;
   assign rsp_fault_cleared = rsp_ff.fault_cleared;
   assign rsp_jump_tracking = rsp_ff.jump_tracking;

`ifndef NO_ASSERTIONS
   // A cleared fault is never reported together with a set flag.
   a_clear_drops_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fault_cleared |-> !rsp_ff.leak_fault)
      else $error("fault_cleared reported with leak_fault still set");

   // A trip that is not cleared in the same beat leaves the flag set.
   a_raise_sets_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fault_raised && !rsp_ff.fault_cleared |-> rsp_ff.leak_fault)
      else $error("fault_raised without leak_fault");

   // Tracking a jump always goes with exactly one baseline kind.
   a_baseline_kind: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctrl_ff.base_kind) &&
      (ctrl_ff.jump_active == (ctrl_ff.base_kind != lcp_pkg::KIND_NONE)))
      else $error("jump_active and base_kind disagree");

   // Run counters wrap before reaching their limits.
   a_counter_limits: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.abs_count < lcp_pkg::ABS_TRIP_RUN) &&
      (ctrl_ff.mid_count < lcp_pkg::MID_TRIP_RUN) &&
      (ctrl_ff.low_count < lcp_pkg::LOW_TRIP_RUN) &&
      (ctrl_ff.calm_count < lcp_pkg::CALM_RUN))
      else $error("run counter past its limit");

   // A beat leaving the input stage always shows up as a result next cycle.
   a_advance_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat lost before the result register");
`endif

endmodule

`default_nettype wire

[hw/rtl/lcp_step.sv]
`default_nettype none

// Next-state logic for one sample pair: quiet period, the absolute, fast,
// mid and low trips, baseline tracking and fault recovery.
module lcp_step #(
   parameter int SAMPLE_BITS = 16
) (
   input  lcp_pkg::cfg_type                 cfg,
   input  lcp_pkg::ctrl_type                ctrl,
   input  logic        [SAMPLE_BITS-1:0]    rms,
   input  logic signed [SAMPLE_BITS-1:0]    avg,
   input  logic                             grid,
   input  logic                             restart,
   input  logic        [SAMPLE_BITS-1:0]    rms_prev2,
   input  logic signed [SAMPLE_BITS-1:0]    avg_prev2,
   input  logic        [SAMPLE_BITS-1:0]    base_rms,
   input  logic signed [SAMPLE_BITS-1:0]    base_avg,
   output lcp_pkg::ctrl_type                ctrl_next,
   output logic        [SAMPLE_BITS-1:0]    base_rms_next,
   output logic signed [SAMPLE_BITS-1:0]    base_avg_next,
   output lcp_pkg::rsp_type                 rsp
);

   localparam int CW = (SAMPLE_BITS > lcp_pkg::LEVEL_W) ? SAMPLE_BITS : lcp_pkg::LEVEL_W;

   // |a - b| of two sign-extended samples; always fits SAMPLE_BITS unsigned
   function automatic logic [SAMPLE_BITS-1:0] mag_diff(
      input logic signed [SAMPLE_BITS:0] a,
      input logic signed [SAMPLE_BITS:0] b
   );
      logic signed [SAMPLE_BITS:0] d;
      d = a - b;
      if (d < 0) begin
         d = -d;
      end
      return d[SAMPLE_BITS-1:0];
   endfunction

   logic [SAMPLE_BITS-1:0] drift;
   logic [SAMPLE_BITS-1:0] d_avg;
   logic [SAMPLE_BITS-1:0] d_rms;
   logic [7:0]             quiet;
   logic                   protect;
   logic                   raised;
   logic                   cleared;
   logic [3:0]             abs_inc;
   logic [3:0]             mid_inc;
   logic [3:0]             low_inc;
   logic [4:0]             calm_inc;
   logic [8:0]             rc_inc;

   assign drift    = mag_diff({avg[SAMPLE_BITS-1], avg}, {avg_prev2[SAMPLE_BITS-1], avg_prev2});
   assign abs_inc  = ctrl.abs_count + 4'd1;
   assign mid_inc  = ctrl.mid_count + 4'd1;
   assign low_inc  = ctrl.low_count + 4'd1;
   assign calm_inc = ctrl.calm_count + 5'd1;

   always_comb begin
      ctrl_next     = ctrl;
      base_rms_next = base_rms;
      base_avg_next = base_avg;
      raised        = 1'b0;
      cleared       = 1'b0;
      d_avg         = '0;
      d_rms         = '0;
      rc_inc        = '0;

      quiet = restart ? 8'd0 : ctrl.quiet_count;
      ctrl_next.quiet_count = quiet;
      protect = 1'b0;
      if (!grid) begin
         ctrl_next.quiet_count = 8'd0;
      end else if (quiet < cfg.quiet_cycles) begin
         ctrl_next.quiet_count = quiet + 8'd1;
      end else begin
         protect = 1'b1;
      end

      // Jump measures: change over two beats, or distance from the baseline
      if (!ctrl.jump_active && (CW'(drift) > CW'(cfg.drift_min_level))) begin
         d_avg = drift;
         d_rms = mag_diff({1'b0, rms}, {1'b0, rms_prev2});
      end else if (ctrl.jump_active) begin
         d_avg = mag_diff({avg[SAMPLE_BITS-1], avg}, {base_avg[SAMPLE_BITS-1], base_avg});
         d_rms = mag_diff({1'b0, rms}, {1'b0, base_rms});
      end

      if (protect) begin
         // Sustained absolute overcurrent
         if (CW'(rms) > CW'(cfg.abs_trip_level)) begin
            if (abs_inc >= lcp_pkg::ABS_TRIP_RUN) begin
               raised              = 1'b1;
               ctrl_next.abs_count = 4'd0;
            end else begin
               ctrl_next.abs_count = abs_inc;
            end
         end else begin
            ctrl_next.abs_count = 4'd0;
         end

         if (CW'(d_rms) >= CW'(cfg.fast_jump_level)) begin
            ctrl_next.low_count   = 4'd0;
            ctrl_next.mid_count   = 4'd0;
            ctrl_next.jump_active = 1'b0;
            ctrl_next.base_kind   = lcp_pkg::KIND_NONE;
            base_avg_next         = '0;
            base_rms_next         = '0;
            raised                = 1'b1;
         end else if (CW'(d_avg) >= CW'(cfg.mid_jump_level)) begin
            ctrl_next.low_count   = 4'd0;
            ctrl_next.jump_active = 1'b1;
            if ((ctrl.base_kind & lcp_pkg::KIND_MID) == lcp_pkg::KIND_NONE) begin
               base_avg_next       = avg_prev2;
               base_rms_next       = rms_prev2;
               ctrl_next.base_kind = lcp_pkg::KIND_MID;
            end
            ctrl_next.mid_count = mid_inc;
            if (mid_inc >= lcp_pkg::MID_TRIP_RUN) begin
               // keep base_rms, drop the rest of the baseline
               ctrl_next.mid_count   = 4'd0;
               ctrl_next.base_kind   = lcp_pkg::KIND_NONE;
               ctrl_next.jump_active = 1'b0;
               base_avg_next         = '0;
               raised                = 1'b1;
            end
         end else if (CW'(d_avg) >= CW'(cfg.low_jump_level)) begin
            ctrl_next.mid_count   = 4'd0;
            ctrl_next.jump_active = 1'b1;
            if ((ctrl.base_kind & lcp_pkg::KIND_LOW) == lcp_pkg::KIND_NONE) begin
               base_avg_next       = avg_prev2;
               base_rms_next       = rms_prev2;
               ctrl_next.base_kind = lcp_pkg::KIND_LOW;
            end
            ctrl_next.low_count = low_inc;
            if (low_inc >= lcp_pkg::LOW_TRIP_RUN) begin
               ctrl_next.low_count   = 4'd0;
               ctrl_next.base_kind   = lcp_pkg::KIND_NONE;
               ctrl_next.jump_active = 1'b0;
               base_avg_next         = '0;
               raised                = 1'b1;
            end
         end else begin
            ctrl_next.low_count  = 4'd0;
            ctrl_next.mid_count  = 4'd0;
            ctrl_next.calm_count = calm_inc;
            if (calm_inc >= lcp_pkg::CALM_RUN) begin
               ctrl_next.calm_count  = 5'd0;
               ctrl_next.jump_active = 1'b0;
               ctrl_next.base_kind   = lcp_pkg::KIND_NONE;
               base_avg_next         = '0;
               base_rms_next         = '0;
            end
         end
      end

      if (raised) begin
         ctrl_next.fault_flag = 1'b1;
      end

      // Recovery: count low readings while faulted, zero on high; else hold
      if (ctrl_next.fault_flag) begin
         if (CW'(rms) < CW'(cfg.recover_level)) begin
            rc_inc = ctrl.recover_count + 9'd1;
            if (rc_inc >= cfg.recover_cycles) begin
               ctrl_next.recover_count = 9'd0;
               ctrl_next.fault_flag    = 1'b0;
               cleared                 = 1'b1;
            end else begin
               ctrl_next.recover_count = rc_inc;
            end
         end else begin
            ctrl_next.recover_count = 9'd0;
         end
      end

      rsp.leak_fault    = ctrl_next.fault_flag;
      rsp.fault_raised  = raised;
      rsp.fault_cleared = cleared;
      rsp.jump_tracking = ctrl_next.jump_active;
   end

endmodule

`default_nettype wire

[tb/tb_leakage_current_protection.sv]
`default_nettype none

// Tracks what the protection block should report for every accepted request beat
// and compares each response beat against the oldest pending expectation.
class trip_scoreboard;
   lcp_pkg::cfg_type    settings;
   logic [15:0]         rms_hist [3];
   logic signed [15:0]  avg_hist [3];
   logic [7:0]          quiet_run;
   logic [3:0]          over_run;
   logic [3:0]          mid_run;
   logic [3:0]          low_run;
   logic [4:0]          calm_run;
   logic                tracking;
   logic [1:0]          base_kind;
   logic signed [15:0]  base_avg;
   logic [15:0]         base_rms;
   logic [8:0]          recover_run;
   logic                faulted;
   lcp_pkg::rsp_type    expected_flags [$];
   int                  checked;
   int                  mismatches;
   int                  trips;
   int                  recoveries;

   function new();
      settings = lcp_pkg::CFG_RESET;
      for (int i = 0; i < 3; i++) begin
         rms_hist[i] = '0;
         avg_hist[i] = '0;
      end
      quiet_run   = '0;
      over_run    = '0;
      mid_run     = '0;
      low_run     = '0;
      calm_run    = '0;
      recover_run = '0;
      faulted     = 1'b0;
      drop_baseline();
      checked     = 0;
      mismatches  = 0;
      trips       = 0;
      recoveries  = 0;
   endfunction

   function void drop_baseline();
      tracking  = 1'b0;
      base_kind = lcp_pkg::KIND_NONE;
      base_avg  = '0;
      base_rms  = '0;
   endfunction

   function int spread(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function void write_reg(logic [lcp_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] data);
      case (idx)
         lcp_pkg::REG_ABS_TRIP:    settings.abs_trip_level  = data;
         lcp_pkg::REG_FAST_JUMP:   settings.fast_jump_level = data;
         lcp_pkg::REG_MID_JUMP:    settings.mid_jump_level  = data;
         lcp_pkg::REG_LOW_JUMP:    settings.low_jump_level  = data;
         lcp_pkg::REG_RECOVER:     settings.recover_level   = data;
         lcp_pkg::REG_DRIFT_MIN:   settings.drift_min_level = data;
         lcp_pkg::REG_QUIET_CYC:   settings.quiet_cycles    = data[7:0];
         lcp_pkg::REG_RECOVER_CYC: settings.recover_cycles  = data[8:0];
         default: ;
      endcase
   endfunction

   function void note_sample(logic [15:0] rms, logic [15:0] avg_raw, logic grid,
                             logic restart);
      logic signed [15:0] avg;
      lcp_pkg::rsp_type   flags;
      int                 drift;
      int                 d_avg;
      int                 d_rms;
      logic               raised;
      logic               cleared;
      avg     = avg_raw;
      raised  = 1'b0;
      cleared = 1'b0;
      d_avg   = 0;
      d_rms   = 0;
      if (restart) quiet_run = '0;
      rms_hist[0] = rms_hist[1];
      rms_hist[1] = rms_hist[2];
      rms_hist[2] = rms;
      avg_hist[0] = avg_hist[1];
      avg_hist[1] = avg_hist[2];
      avg_hist[2] = avg;

      if (!grid) begin
         quiet_run = '0;
      end else if (quiet_run < settings.quiet_cycles) begin
         quiet_run = quiet_run + 1'b1;
      end else begin
         drift = spread(int'(avg_hist[2]), int'(avg_hist[0]));
         if (rms > settings.abs_trip_level) begin
            over_run = over_run + 1'b1;
            if (over_run >= lcp_pkg::ABS_TRIP_RUN) begin
               raised   = 1'b1;
               over_run = '0;
            end
         end else begin
            over_run = '0;
         end

         if (!tracking && drift > int'(settings.drift_min_level)) begin
            d_avg = drift;
            d_rms = spread(int'(rms_hist[2]), int'(rms_hist[0]));
         end else if (tracking) begin
            d_avg = spread(int'(avg_hist[2]), int'(base_avg));
            d_rms = spread(int'(rms_hist[2]), int'(base_rms));
         end

         if (d_rms >= int'(settings.fast_jump_level)) begin
            low_run = '0;
            mid_run = '0;
            drop_baseline();
            raised = 1'b1;
         end else if (d_avg >= int'(settings.mid_jump_level)) begin
            low_run  = '0;
            tracking = 1'b1;
            if ((base_kind & lcp_pkg::KIND_MID) == lcp_pkg::KIND_NONE) begin
               base_avg  = avg_hist[0];
               base_rms  = rms_hist[0];
               base_kind = lcp_pkg::KIND_MID;
            end
            mid_run = mid_run + 1'b1;
            if (mid_run >= lcp_pkg::MID_TRIP_RUN) begin
               // mid trip keeps the RMS baseline
               mid_run   = '0;
               base_kind = lcp_pkg::KIND_NONE;
               tracking  = 1'b0;
               base_avg  = '0;
               raised    = 1'b1;
            end
         end else if (d_avg >= int'(settings.low_jump_level)) begin
            mid_run  = '0;
            tracking = 1'b1;
            if ((base_kind & lcp_pkg::KIND_LOW) == lcp_pkg::KIND_NONE) begin
               base_avg  = avg_hist[0];
               base_rms  = rms_hist[0];
               base_kind = lcp_pkg::KIND_LOW;
            end
            low_run = low_run + 1'b1;
            if (low_run >= lcp_pkg::LOW_TRIP_RUN) begin
               low_run   = '0;
               base_avg  = '0;
               base_kind = lcp_pkg::KIND_NONE;
               tracking  = 1'b0;
               raised    = 1'b1;
            end
         end else begin
            low_run  = '0;
            mid_run  = '0;
            calm_run = calm_run + 1'b1;
            if (calm_run >= lcp_pkg::CALM_RUN) begin
               calm_run = '0;
               drop_baseline();
            end
         end
      end

      if (raised) faulted = 1'b1;
      if (faulted) begin
         if (rms < settings.recover_level) begin
            recover_run = recover_run + 1'b1;
            if (recover_run >= settings.recover_cycles) begin
               recover_run = '0;
               faulted     = 1'b0;
               cleared     = 1'b1;
            end
         end else begin
            recover_run = '0;
         end
      end

      if (raised) trips++;
      if (cleared) recoveries++;
      flags.leak_fault    = faulted;
      flags.fault_raised  = raised;
      flags.fault_cleared = cleared;
      flags.jump_tracking = tracking;
      expected_flags.push_back(flags);
   endfunction

   function void complain(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
   endfunction

   function void check_flags(lcp_pkg::rsp_type got);
      lcp_pkg::rsp_type want;
      if (expected_flags.size() == 0) begin
         complain($sformatf({"response beat with no request pending: ",
                             "fault=%0b raised=%0b cleared=%0b track=%0b"},
                            got.leak_fault, got.fault_raised, got.fault_cleared,
                            got.jump_tracking));
         return;
      end
      want = expected_flags.pop_front();
      checked++;
      if (got != want)
         complain($sformatf({"response %0d: expected fault=%0b raised=%0b cleared=%0b ",
                             "track=%0b, got fault=%0b raised=%0b cleared=%0b track=%0b"},
                            checked, want.leak_fault, want.fault_raised,
                            want.fault_cleared, want.jump_tracking, got.leak_fault,
                            got.fault_raised, got.fault_cleared, got.jump_tracking));
   endfunction

   function int pending();
      return expected_flags.size();
   endfunction

   function void flag_leftovers();
      if (expected_flags.size() != 0)
         complain($sformatf("%0d responses never arrived", expected_flags.size()));
   endfunction
endclass

module tb_leakage_current_protection;

   // Every block input starts at a known value; reset is held high from time zero.
   logic                              clock              = 1'b0;
   logic                              reset              = 1'b1;
   logic                              req_valid          = 1'b0;
   logic                              req_ready;
   logic [15:0]                       req_rms_sample     = '0;
   logic signed [15:0]                req_avg_sample     = '0;
   logic                              req_grid_connected = 1'b0;
   logic                              req_restart_quiet  = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready          = 1'b1;
   logic                              rsp_leak_fault;
   logic                              rsp_fault_raised;
   logic                              rsp_fault_cleared;
   logic                              rsp_jump_tracking;
   logic                              csr_we             = 1'b0;
   logic [lcp_pkg::CSR_INDEX_W-1:0]   csr_index          = '0;
   logic [lcp_pkg::LEVEL_W-1:0]       csr_wdata          = '0;

   trip_scoreboard                    sb;
   lcp_pkg::cfg_type                  cur_cfg = lcp_pkg::CFG_RESET;
   bit                                idle_on = 1'b1;
   int                                floor_rms = 100;
   int                                floor_avg = 0;
   int                                samples_sent = 0;
   int                                settings_used = 0;
   lcp_pkg::rsp_type                  got_flags;

   leakage_current_protection #(.SAMPLE_BITS(16)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rms_sample     (req_rms_sample),
      .req_avg_sample     (req_avg_sample),
      .req_grid_connected (req_grid_connected),
      .req_restart_quiet  (req_restart_quiet),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_leak_fault     (rsp_leak_fault),
      .rsp_fault_raised   (rsp_fault_raised),
      .rsp_fault_cleared  (rsp_fault_cleared),
      .rsp_jump_tracking  (rsp_jump_tracking),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Generous ceiling: a few hundred beats with random stalls need far less.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   // Response side: check each accepted beat, then pick the stall for the next edge.
   // Outputs are read right at the edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_flags = {rsp_leak_fault, rsp_fault_raised, rsp_fault_cleared,
                      rsp_jump_tracking};
         sb.check_flags(got_flags);
      end
      rsp_ready <= !(idle_on && $urandom_range(99) < 17);
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Present one request beat, optionally after a few idle cycles, and hold it
   // until accepted. Valid stays high on return so back-to-back beats never dip.
   task automatic send_sample(input logic [15:0] rms, input logic [15:0] avg,
                              input logic grid, input logic restart);
      while (idle_on && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_rms_sample     <= rms;
      req_avg_sample     <= avg;
      req_grid_connected <= grid;
      req_restart_quiet  <= restart;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(rms, avg, grid, restart);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [lcp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Write the whole register set; only called while the block is idle.
   task automatic load_settings(input lcp_pkg::cfg_type c);
      write_reg(lcp_pkg::REG_ABS_TRIP,    c.abs_trip_level);
      write_reg(lcp_pkg::REG_FAST_JUMP,   c.fast_jump_level);
      write_reg(lcp_pkg::REG_MID_JUMP,    c.mid_jump_level);
      write_reg(lcp_pkg::REG_LOW_JUMP,    c.low_jump_level);
      write_reg(lcp_pkg::REG_RECOVER,     c.recover_level);
      write_reg(lcp_pkg::REG_DRIFT_MIN,   c.drift_min_level);
      write_reg(lcp_pkg::REG_QUIET_CYC,   16'(c.quiet_cycles));
      write_reg(lcp_pkg::REG_RECOVER_CYC, 16'(c.recover_cycles));
      csr_we  <= 1'b0;
      cur_cfg  = c;
      settings_used++;
   endtask

   // Drop valid, wait for every pending response (bounded), then let the
   // two-stage pipe go quiet before anything else touches the registers.
   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Random traffic built from short scenarios scaled to the current thresholds:
   // steady load, sustained overcurrent, average steps, RMS spikes, low readings
   // that let a fault recover, and raw noise with grid drops and self-test restarts.
   task automatic run_traffic(input int n, input int noise_pct);
      int left;
      int span;
      int pick;
      int r;
      int a;
      int step;
      int abs_lvl;
      int fast_lvl;
      int mid_lvl;
      int low_lvl;
      int rec_lvl;
      int drift_lvl;
      bit g;
      bit q;
      abs_lvl   = int'(cur_cfg.abs_trip_level);
      fast_lvl  = int'(cur_cfg.fast_jump_level);
      mid_lvl   = int'(cur_cfg.mid_jump_level);
      low_lvl   = int'(cur_cfg.low_jump_level);
      rec_lvl   = int'(cur_cfg.recover_level);
      drift_lvl = int'(cur_cfg.drift_min_level);
      left = n;
      while (left > 0) begin
         pick = ($urandom_range(99) < 3 * noise_pct) ? 5 : int'($urandom_range(4));
         case (pick)
            0: begin
               span      = $urandom_range(25, 5);
               floor_rms = $urandom_range(400);
               floor_avg = int'($urandom_range(600)) - 300;
            end
            1: span = $urandom_range(16, 10);
            2: begin
               // step the average by about one of the jump levels and hold it
               span = $urandom_range(12, 6);
               if ($urandom_range(2) == 0)
                  step = low_lvl;
               else if ($urandom_range(1) == 1)
                  step = mid_lvl;
               else
                  step = int'($urandom_range(mid_lvl + 100, low_lvl));
               floor_avg = clamp($urandom_range(1) ? floor_avg + step : floor_avg - step,
                                 -32768, 32767);
            end
            3: span = $urandom_range(3, 1);
            4: span = $urandom_range(40, 5);
            default: span = $urandom_range(6, 1);
         endcase
         if (span > left) span = left;
         repeat (span) begin
            g = 1'b1;
            q = 1'b0;
            r = floor_rms + int'($urandom_range(15));
            a = floor_avg + int'($urandom_range(8)) - 4;
            case (pick)
               // now and then sit exactly on the level, which must not count
               1: r = ($urandom_range(11) == 0) ? abs_lvl
                                                : abs_lvl + 1 + int'($urandom_range(200));
               3: begin
                  r = floor_rms + fast_lvl + int'($urandom_range(50));
                  a = floor_avg + drift_lvl + 1 + int'($urandom_range(20));
               end
               4: r = (rec_lvl > 0) ? int'($urandom_range(rec_lvl - 1)) : 0;
               5: begin
                  r = $urandom_range(65535);
                  a = int'($urandom_range(65535)) - 32768;
                  g = $urandom_range(1);
                  q = $urandom_range(1);
               end
               default: ;
            endcase
            if ($urandom_range(99) < noise_pct) g = 1'b0;
            if ($urandom_range(99) == 0) q = 1'b1;
            send_sample(16'(clamp(r, 0, 65535)), 16'(clamp(a, -32768, 32767)), g, q);
         end
         left -= span;
      end
   endtask

   initial begin
      lcp_pkg::cfg_type c;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats with a short quiet period and quick recovery.
      c = lcp_pkg::CFG_RESET;
      c.quiet_cycles   = 8'd2;
      c.recover_cycles = 9'd3;
      load_settings(c);
      send_sample(16'd0,     16'sd0,      1'b0, 1'b0);  // disconnected
      send_sample(16'd100,   16'sd0,      1'b1, 1'b0);  // quiet
      send_sample(16'd100,   16'sd0,      1'b1, 1'b0);  // quiet
      send_sample(16'd100,   16'sd0,      1'b1, 1'b1);  // self-test ends, restart quiet
      send_sample(16'd100,   16'sd0,      1'b1, 1'b0);
      send_sample(16'd100,   16'sd5,      1'b1, 1'b0);  // drift under the minimum
      send_sample(16'd100,   16'sd0,      1'b1, 1'b0);
      send_sample(16'd1400,  16'sd20,     1'b1, 1'b0);  // RMS jump trips at once
      send_sample(16'd0,     16'sd20,     1'b1, 1'b0);  // low readings clear it
      send_sample(16'd0,     16'sd20,     1'b1, 1'b0);
      send_sample(16'd0,     16'sd20,     1'b1, 1'b0);
      send_sample(16'd50,    16'sd600,    1'b1, 1'b0);  // average step, mid baseline
      send_sample(16'd50,    16'sd600,    1'b1, 1'b0);
      send_sample(16'd50,    16'sd600,    1'b1, 1'b0);
      send_sample(16'd50,    16'sd600,    1'b1, 1'b0);
      send_sample(16'hFFFF,  16'sh8000,   1'b1, 1'b0);  // field extremes
      send_sample(16'hFFFF,  16'sh7FFF,   1'b1, 1'b0);
      send_sample(16'd0,     16'sh8000,   1'b1, 1'b0);
      send_sample(16'd0,     16'sh7FFF,   1'b0, 1'b1);  // disconnected during restart
      send_sample(16'd3000,  16'sd300,    1'b1, 1'b0);
      send_sample(16'd3000,  16'sd300,    1'b1, 1'b0);
      send_sample(16'd3000,  16'sd0,      1'b1, 1'b0);  // low-level average step
      send_sample(16'd0,     16'sd0,      1'b1, 1'b0);
      send_sample(16'd0,     16'sd0,      1'b1, 1'b0);
      settle();

      // Nominal levels, short quiet period.
      c = lcp_pkg::CFG_RESET;
      c.quiet_cycles   = 8'd4;
      c.recover_cycles = 9'd12;
      load_settings(c);
      run_traffic(130, 4);
      settle();

      // Every level at zero: each protected beat trips.
      c = '0;
      c.recover_cycles = 9'd1;
      load_settings(c);
      run_traffic(50, 4);
      settle();

      // Every register at its top value.
      c = '1;
      load_settings(c);
      run_traffic(50, 2);
      settle();

      // Power-on defaults, grid held so the long quiet period runs out.
      load_settings(lcp_pkg::CFG_RESET);
      run_traffic(170, 0);
      settle();

      // Random levels, no stalls on either side for the whole stretch.
      c.abs_trip_level  = 16'($urandom_range(3000, 200));
      c.fast_jump_level = 16'($urandom_range(2000, 300));
      c.mid_jump_level  = 16'($urandom_range(600, 100));
      c.low_jump_level  = 16'($urandom_range(c.mid_jump_level, 50));
      c.recover_level   = 16'($urandom_range(1000, 100));
      c.drift_min_level = 16'($urandom_range(30));
      c.quiet_cycles    = 8'($urandom_range(6));
      c.recover_cycles  = 9'($urandom_range(30, 1));
      load_settings(c);
      idle_on = 1'b0;
      run_traffic(150, 5);
      settle();

      sb.flag_leftovers();
      $display("Drove %0d samples through %0d threshold settings; %0d responses checked.",
               samples_sent, settings_used, sb.checked);
      $display("The run expected %0d trips and %0d fault clears; %0d mismatches seen.",
               sb.trips, sb.recoveries, sb.mismatches);
      if (sb.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

`default_nettype wire
